### hw/rtl/aurb_pkg.sv
// Shared types and address map of the APB UART register block.
package aurb_pkg;

    typedef struct packed {
        logic        psel;
        logic        penable;
        logic        req_type;
        logic [15:0] paddr;
        logic [7:0]  pwdata;
        logic [3:0]  pstrb;
        logic [8:0]  uart_status;
        logic [7:0]  rx_byte;
    } aurb_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       slave_error;
        logic       tx_load;
        logic       rx_data_read;
        logic [7:0] tx_data;
        logic [6:0] line_control;
        logic [4:0] irq_flags;
        logic       shift_rx;
        logic       shift_tx;
    } aurb_rsp_t;

    localparam logic [4:0] OFS_CTRL    = 5'h00;
    localparam logic [4:0] OFS_STATUS  = 5'h04;
    localparam logic [4:0] OFS_BAUD    = 5'h08;
    localparam logic [4:0] OFS_DATA    = 5'h0C;
    localparam logic [4:0] OFS_IRQ_EN  = 5'h10;
    localparam logic [4:0] OFS_RAW     = 5'h14;
    localparam logic [4:0] OFS_MASKED  = 5'h18;

    localparam logic [15:0] ADDR_LIMIT = 16'h0018;
    localparam logic [3:0]  TX_TICK_LAST = 4'd15;

    localparam int ST_TXNOTFULL  = 5;
    localparam int ST_RXNOTEMPTY = 6;
    localparam int ST_TXBUSY     = 7;
    localparam int ST_RXBUSY     = 8;

endpackage

### hw/rtl/aurb_in_stage.sv
// Input register of the APB UART register block.
module aurb_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  aurb_pkg::aurb_req_t req,
    input  logic               advance,
    output logic               item_valid,
    output aurb_pkg::aurb_req_t item
);
    import aurb_pkg::*;

    logic      valid_reg;
    aurb_req_t item_reg;

    assign req_stall  = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            item_reg <= req;
        end
    end

endmodule

### hw/rtl/aurb_core.sv
// Register file, address decode, error check and baud tick counters.
module aurb_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  aurb_pkg::aurb_req_t item,
    output aurb_pkg::aurb_rsp_t result
);
    import aurb_pkg::*;

    logic [3:0] control_reg;
    logic [2:0] status_enable_reg;
    logic [7:0] baud_reg;
    logic [4:0] irq_enable_reg;
    logic [7:0] rx_tick_count_reg;
    logic [3:0] tx_tick_count_reg;
    logic       error_flag_reg;

    logic [7:0] rx_tick_count_next;
    logic [3:0] tx_tick_count_next;

    logic [4:0] off;
    logic       access;
    logic       strb_all;
    logic       reg_we;
    logic       reg_re;
    logic [4:0] flags;
    logic [4:0] masked;
    logic       busy;
    logic       shift_rx;
    logic       shift_tx;
    logic       uart_en;
    logic       err;
    logic [7:0] rdata;

    assign off      = item.paddr[4:0];
    assign access   = item.psel && item.penable;
    assign strb_all = (item.pstrb == 4'hF);
    assign reg_we   = item.req_type && access && strb_all;
    assign reg_re   = !item.req_type && access;
    assign flags    = item.uart_status[4:0];
    assign masked   = flags & irq_enable_reg;
    assign busy     = item.uart_status[ST_TXBUSY] || item.uart_status[ST_RXBUSY];
    assign shift_rx = (rx_tick_count_reg == baud_reg);
    assign shift_tx = shift_rx && (tx_tick_count_reg == TX_TICK_LAST);
    assign uart_en  = status_enable_reg[0];
    assign err      = (item.paddr[1:0] != 2'b00) || (item.paddr >= ADDR_LIMIT)
                      || (!strb_all && item.req_type && access);

    always_comb
    begin
        case (off)
            OFS_CTRL:   rdata = {4'b0000, control_reg};
            OFS_STATUS: rdata = {busy, item.uart_status[ST_RXNOTEMPTY],
                                 item.uart_status[ST_TXNOTFULL], 2'b00, status_enable_reg};
            OFS_BAUD:   rdata = baud_reg;
            OFS_DATA:   rdata = item.rx_byte;
            OFS_IRQ_EN: rdata = {3'b000, irq_enable_reg};
            OFS_RAW:    rdata = {3'b000, flags};
            OFS_MASKED: rdata = {3'b000, masked};
            default:    rdata = 8'h00;
        endcase
    end

    always_comb
    begin
        result.read_data    = rdata;
        result.slave_error  = error_flag_reg;
        result.tx_load      = reg_we && (off == OFS_DATA);
        result.rx_data_read = reg_re && (off == OFS_DATA);
        result.tx_data      = item.pwdata;
        result.line_control = {status_enable_reg, control_reg};
        result.irq_flags    = masked;
        result.shift_rx     = shift_rx;
        result.shift_tx     = shift_tx;
    end

    always_comb
    begin
        if (!uart_en)
        begin
            rx_tick_count_next = 8'h00;
            tx_tick_count_next = 4'h0;
        end
        else if (shift_rx)
        begin
            rx_tick_count_next = 8'h00;
            tx_tick_count_next = tx_tick_count_reg + 4'd1;
        end
        else
        begin
            rx_tick_count_next = rx_tick_count_reg + 8'd1;
            tx_tick_count_next = tx_tick_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg       <= '0;
            status_enable_reg <= '0;
            baud_reg          <= '0;
            irq_enable_reg    <= '0;
            rx_tick_count_reg <= '0;
            tx_tick_count_reg <= '0;
            error_flag_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (reg_we)
            begin
                case (off)
                    OFS_CTRL:   control_reg       <= item.pwdata[3:0];
                    OFS_STATUS: status_enable_reg <= item.pwdata[2:0];
                    OFS_BAUD:   baud_reg          <= item.pwdata;
                    OFS_IRQ_EN: irq_enable_reg    <= item.pwdata[4:0];
                    default:    ;
                endcase
            end
            rx_tick_count_reg <= rx_tick_count_next;
            tx_tick_count_reg <= tx_tick_count_next;
            error_flag_reg    <= item.psel && err;
        end
    end

    // receive tick counter restarts after a receive tick
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && uart_en && shift_rx |=> rx_tick_count_reg == 8'h00)
        else $error("rx tick counter did not restart after tick");

    // disabled UART holds counters at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !uart_en |=> rx_tick_count_reg == 8'h00 && tx_tick_count_reg == 4'h0)
        else $error("tick counters moved while UART disabled");

    // unselected beat never flags an error
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.psel |=> !error_flag_reg)
        else $error("slave error without select");

    // partial-strobe write leaves the control register alone
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.req_type && !strb_all |=> $stable(control_reg))
        else $error("control register written by partial-strobe beat");

endmodule

### hw/rtl/aurb_out_stage.sv
// Result register of the APB UART register block.
module aurb_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  aurb_pkg::aurb_rsp_t result,
    output logic                advance,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output aurb_pkg::aurb_rsp_t rsp
);
    import aurb_pkg::*;

    logic      valid_reg;
    aurb_rsp_t rsp_reg;

    assign advance   = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            rsp_reg <= result;
        end
    end

endmodule

### hw/rtl/apb_uart_register_block_unit.sv
// Top level of the APB UART register block.
// Each request beat is one APB clock cycle of the slave; the block answers every beat with one
// response beat carrying read data, the registered slave error of the previous beat (clear if
// it was unselected), transmit load and receive read strobes, line control, masked interrupts
// and baud ticks. A beat passes an input register, one level of decode and register-file logic,
// and a result register; a new beat is taken every cycle while the response side keeps up.
// Register writes, counter steps and the error flag advance as each beat leaves the input
// register.
module apb_uart_register_block_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  aurb_pkg::aurb_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output aurb_pkg::aurb_rsp_t rsp
);
    import aurb_pkg::*;

    logic      advance;
    logic      item_valid;
    aurb_req_t item;
    aurb_rsp_t result;

    aurb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    aurb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (item_valid && advance),
        .item   (item),
        .result (result)
    );

    aurb_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

### sim/tb.sv
// Self-checking testbench for the APB UART register block: predicts each response beat.
`timescale 1ns / 1ps

module tb;
    import aurb_pkg::*;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;
    localparam logic [3:0] STRB_ALL = 4'hF;
    localparam int RANDOM_BEATS = 550;
    localparam int QUIET_FROM = 450;

    class uart_regfile_model;
        logic [3:0] ctrl;
        logic [2:0] stat_en;
        logic [7:0] baud;
        logic [4:0] irq_en;
        logic [7:0] rx_cnt;
        logic [3:0] tx_cnt;
        logic       err_q;
        aurb_rsp_t  expected_rsp_q[$];
        int         n_beats;
        int         n_writes;
        int         n_errors;
        int         n_tx_ticks;
        int         n_checked;
        int         n_mismatch;

        function new();
            ctrl = '0;
            stat_en = '0;
            baud = '0;
            irq_en = '0;
            rx_cnt = '0;
            tx_cnt = '0;
            err_q = 1'b0;
            n_beats = 0;
            n_writes = 0;
            n_errors = 0;
            n_tx_ticks = 0;
            n_checked = 0;
            n_mismatch = 0;
        endfunction

        function int pending();
            return expected_rsp_q.size();
        endfunction

        function void take_request(aurb_req_t r);
            aurb_rsp_t  e;
            logic [4:0] ofs;
            logic [4:0] raw;
            logic       acc;
            logic       strb_full;
            logic       wr_ok;
            logic       rd;
            logic       busy;
            logic       bad;
            logic       tick_rx;
            logic       uart_on;

            ofs = r.paddr[4:0];
            raw = r.uart_status[4:0];
            acc = r.psel && r.penable;
            strb_full = &r.pstrb;
            wr_ok = acc && r.req_type == REQ_WRITE && strb_full;
            rd = acc && r.req_type == REQ_READ;
            busy = r.uart_status[ST_TXBUSY] | r.uart_status[ST_RXBUSY];

            case (ofs)
                OFS_CTRL:   e.read_data = {4'b0, ctrl};
                OFS_STATUS: e.read_data = {busy, r.uart_status[ST_RXNOTEMPTY],
                                           r.uart_status[ST_TXNOTFULL], 2'b00, stat_en};
                OFS_BAUD:   e.read_data = baud;
                OFS_DATA:   e.read_data = r.rx_byte;
                OFS_IRQ_EN: e.read_data = {3'b0, irq_en};
                OFS_RAW:    e.read_data = {3'b0, raw};
                OFS_MASKED: e.read_data = {3'b0, raw & irq_en};
                default:    e.read_data = 8'h00;
            endcase
            tick_rx = rx_cnt == baud;
            e.slave_error = err_q;
            e.tx_load = wr_ok && ofs == OFS_DATA;
            e.rx_data_read = rd && ofs == OFS_DATA;
            e.tx_data = r.pwdata;
            e.line_control = {stat_en, ctrl};
            e.irq_flags = raw & irq_en;
            e.shift_rx = tick_rx;
            e.shift_tx = tick_rx && tx_cnt == TX_TICK_LAST;
            bad = r.paddr[1:0] != 2'b00 || r.paddr >= ADDR_LIMIT ||
                  (acc && r.req_type == REQ_WRITE && !strb_full);
            uart_on = stat_en[0];

            if (wr_ok)
            begin
                case (ofs)
                    OFS_CTRL:   ctrl = r.pwdata[3:0];
                    OFS_STATUS: stat_en = r.pwdata[2:0];
                    OFS_BAUD:   baud = r.pwdata;
                    OFS_IRQ_EN: irq_en = r.pwdata[4:0];
                    default:    ;
                endcase
            end
            if (!uart_on)
            begin
                rx_cnt = '0;
                tx_cnt = '0;
            end
            else if (tick_rx)
            begin
                rx_cnt = '0;
                tx_cnt = tx_cnt + 4'd1;
            end
            else
            begin
                rx_cnt = rx_cnt + 8'd1;
            end
            err_q = r.psel && bad;

            n_beats++;
            if (wr_ok) n_writes++;
            if (r.psel && bad) n_errors++;
            if (e.shift_tx) n_tx_ticks++;
            expected_rsp_q.push_back(e);
        endfunction

        function void check_response(aurb_rsp_t got);
            aurb_rsp_t e;
            string     wrong;

            if (expected_rsp_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected response beat %h", got);
                return;
            end
            e = expected_rsp_q.pop_front();
            wrong = "";
            if (got.read_data !== e.read_data) wrong = {wrong, " read_data"};
            if (got.slave_error !== e.slave_error) wrong = {wrong, " slave_error"};
            if (got.tx_load !== e.tx_load) wrong = {wrong, " tx_load"};
            if (got.rx_data_read !== e.rx_data_read) wrong = {wrong, " rx_data_read"};
            if (got.tx_data !== e.tx_data) wrong = {wrong, " tx_data"};
            if (got.line_control !== e.line_control) wrong = {wrong, " line_control"};
            if (got.irq_flags !== e.irq_flags) wrong = {wrong, " irq_flags"};
            if (got.shift_rx !== e.shift_rx) wrong = {wrong, " shift_rx"};
            if (got.shift_tx !== e.shift_tx) wrong = {wrong, " shift_tx"};
            if (wrong != "")
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("response %0d mismatch:%s expected %h got %h",
                             n_checked, wrong, e, got);
            end
            n_checked++;
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    aurb_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    aurb_rsp_t rsp;

    uart_regfile_model model;
    bit quiet = 1'b0;
    int stall_left = 0;
    int random_sent = 0;

    apb_uart_register_block_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (!quiet && rst_n && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            model.check_response(rsp);
    end

    function automatic aurb_req_t beat(input logic sel, input logic en, input logic wr,
                                       input logic [15:0] addr, input logic [7:0] data,
                                       input logic [3:0] strb);
        aurb_req_t b;
        b.psel = sel;
        b.penable = en;
        b.req_type = wr;
        b.paddr = addr;
        b.pwdata = data;
        b.pstrb = strb;
        b.uart_status = 9'($urandom_range(0, 511));
        b.rx_byte = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [15:0] pick_addr();
        logic [31:0] r;
        logic [4:0]  ofs;
        int          k;
        r = $urandom;
        k = $urandom_range(0, 19);
        ofs = 5'($urandom_range(0, 7) * 4);
        if (k < 14)
            return {11'b0, ofs};
        else if (k < 17)
            return {r[15:5], ofs};
        else
            return r[15:0];
    endfunction

    task automatic drive(input aurb_req_t item);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        model.take_request(item);
    endtask

    task automatic write_reg(input logic [15:0] addr, input logic [7:0] data);
        drive(beat(1'b1, 1'b1, REQ_WRITE, addr, data, STRB_ALL));
    endtask

    task automatic read_reg(input logic [15:0] addr);
        drive(beat(1'b1, 1'b1, REQ_READ, addr, 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15))));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [15:0] addr,
                                input logic [7:0] data, input logic [3:0] strb);
        aurb_req_t b;
        b = beat(1'b1, 1'b0, wr, addr, data, strb);
        drive(b);
        b.penable = 1'b1;
        b.uart_status = 9'($urandom_range(0, 511));
        b.rx_byte = 8'($urandom_range(0, 255));
        drive(b);
        random_sent += 2;
    endtask

    task automatic random_transfer();
        logic [15:0] addr;
        logic [7:0]  data;
        logic [3:0]  strb;
        logic        wr;
        addr = pick_addr();
        wr = 1'($urandom_range(0, 1));
        data = 8'($urandom_range(0, 255));
        strb = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : STRB_ALL;
        if (wr && addr[4:0] == OFS_BAUD && $urandom_range(0, 3) != 0)
            data = 8'($urandom_range(0, 3));
        if (wr && addr[4:0] == OFS_STATUS && $urandom_range(0, 3) != 0)
            data[0] = 1'b1;
        apb_transfer(wr, addr, data, strb);
    endtask

    task automatic counter_wrap_run();
        aurb_req_t b;
        write_reg({11'b0, OFS_BAUD}, 8'hC8);
        write_reg({11'b0, OFS_STATUS}, 8'h01);
        repeat (20)
            drive(beat(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_addr(),
                       8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
        write_reg({11'b0, OFS_BAUD}, 8'h02);
        repeat (240)
        begin
            b = beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), REQ_READ, pick_addr(),
                     8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            drive(b);
        end
        random_sent += 263;
    endtask

    initial
    begin
        int  kind;
        bit  wrap_done;
        bit  mid_drain_done;

        model = new();
        wrap_done = 1'b0;
        mid_drain_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive('0);
        write_reg({11'b0, OFS_CTRL}, 8'hFF);
        write_reg({11'b0, OFS_BAUD}, 8'h00);
        write_reg({11'b0, OFS_STATUS}, 8'h07);
        write_reg({11'b0, OFS_IRQ_EN}, 8'hFF);
        write_reg({11'b0, OFS_DATA}, 8'hA5);
        drive(beat(1'b1, 1'b1, REQ_READ, {11'b0, OFS_DATA}, 8'h00, 4'h0));
        for (int i = 0; i < 8; i++)
            read_reg(16'(i * 4));
        drive(beat(1'b1, 1'b1, REQ_READ, 16'h0001, 8'hFF, STRB_ALL));
        drive(beat(1'b1, 1'b1, REQ_WRITE, 16'h0006, 8'h00, STRB_ALL));
        drive(beat(1'b1, 1'b1, REQ_WRITE, {11'b0, OFS_CTRL}, 8'h00, 4'h7));
        write_reg({11'b0, OFS_RAW}, 8'hFF);
        write_reg({11'b0, OFS_MASKED}, 8'hFF);
        write_reg(16'h0028, 8'h03);
        read_reg(16'hFFFF);
        drive(beat(1'b1, 1'b0, REQ_WRITE, {11'b0, OFS_CTRL}, 8'h05, STRB_ALL));
        drive(beat(1'b0, 1'b1, REQ_WRITE, {11'b0, OFS_CTRL}, 8'h06, STRB_ALL));
        write_reg({11'b0, OFS_STATUS}, 8'h00);
        write_reg({11'b0, OFS_BAUD}, 8'hFF);

        drain();
        while (random_sent < RANDOM_BEATS)
        begin
            if (random_sent >= QUIET_FROM) quiet = 1'b1;
            if (!mid_drain_done && random_sent >= RANDOM_BEATS / 2)
            begin
                drain();
                mid_drain_done = 1'b1;
            end
            kind = $urandom_range(0, 19);
            if (!wrap_done && random_sent >= 80)
            begin
                counter_wrap_run();
                wrap_done = 1'b1;
            end
            else if (kind < 12)
            begin
                random_transfer();
                if ($urandom_range(0, 2) == 0)
                begin
                    drive(beat(1'b0, 1'b0, 1'($urandom_range(0, 1)), pick_addr(),
                               8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
                    random_sent++;
                end
            end
            else if (kind < 17)
            begin
                drive(beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 16'($urandom),
                           8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
                random_sent++;
            end
            else if (kind < 19)
            begin
                drive(beat(1'b1, 1'b1, 1'($urandom_range(0, 1)), pick_addr(),
                           8'($urandom_range(0, 255)), STRB_ALL));
                random_sent++;
            end
            else
            begin
                drive(beat(1'b1, 1'b0, REQ_WRITE, pick_addr(), 8'($urandom_range(0, 255)),
                           STRB_ALL));
                drive(beat(1'b1, 1'b1, 1'($urandom_range(0, 1)), pick_addr(),
                           8'($urandom_range(0, 255)), 4'($urandom_range(0, 15))));
                random_sent += 2;
            end
        end

        req_valid <= 1'b0;
        while (model.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d request beats: %0d register writes, %0d error beats",
                 model.n_beats, model.n_writes, model.n_errors);
        $display("%0d transmit ticks seen, %0d responses checked, %0d mismatches",
                 model.n_tx_ticks, model.n_checked, model.n_mismatch);
        if (model.n_mismatch == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
